>>> hdl/rppt_pkg.sv
// rppt_pkg: shared types and character constants for the roll plan text parser
// used by rppt_front, rppt_queue, rppt_back and roll_plan_text_parser_core
// no dependencies

package rppt_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [9:0]  HEAD_MOD    = 10'd360;
    localparam logic [9:0]  HEAD_MOD_X2 = 10'd720;
    localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
    localparam logic [2:0]  HEAD_DIGITS = 3'd3;
    localparam logic [2:0]  TIME_DIGITS = 3'd4;

    localparam logic [1:0] DIR_CW       = 2'd0;
    localparam logic [1:0] DIR_CCW      = 2'd1;
    localparam logic [1:0] DIR_SHORTEST = 2'd2;

    typedef enum logic [2:0] {
        CC_DIGIT,
        CC_HASH,
        CC_PLUS,
        CC_MINUS,
        CC_TILDE,
        CC_SEMI,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        restart;
    } token_t;

    typedef enum logic [2:0] {
        PH_HASH,
        PH_COUNT,
        PH_DIR,
        PH_HEAD,
        PH_TIME,
        PH_SEMI,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic        ready;
        logic [1:0]  dir;
        logic [8:0]  head;
        logic [13:0] tms;
        logic [15:0] idx;
        logic        valid;
        logic        err;
    } result_t;

endpackage

>>> hdl/rppt_front.sv
// rppt_front: classifies each incoming text byte into a token
// depends on rppt_pkg

module rppt_front
    import rppt_pkg::*;
(
    input  logic [7:0] text_byte,
    input  logic       plan_start,
    output token_t     token
);

    logic [7:0] digit_wide;

    assign digit_wide = text_byte - CH_ZERO;

    always_comb
    begin
        token.restart = plan_start;
        token.digit   = digit_wide[3:0];
        case (text_byte) inside
            [CH_ZERO:CH_NINE]: token.cls = CC_DIGIT;
            CH_HASH:           token.cls = CC_HASH;
            CH_PLUS:           token.cls = CC_PLUS;
            CH_MINUS:          token.cls = CC_MINUS;
            CH_TILDE:          token.cls = CC_TILDE;
            CH_SEMI:           token.cls = CC_SEMI;
            default:           token.cls = CC_OTHER;
        endcase
    end

endmodule

>>> hdl/rppt_queue.sv
// rppt_queue: small token queue between the classifier and the parser
// depends on rppt_pkg

module rppt_queue
    import rppt_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output token_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    token_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> hdl/rppt_back.sv
// rppt_back: plan parser state machine and registered result stage
// depends on rppt_pkg

module rppt_back
    import rppt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    input  token_t  tok,
    output logic    tok_pop,
    output logic    res_valid,
    input  logic    res_stall,
    output result_t res
);

    phase_t      phase_reg, phase_next, phase_cur;
    logic [15:0] expected_reg, expected_next, expected_cur;
    logic [15:0] done_reg, done_next, done_cur, done_inc;
    logic [2:0]  pos_reg, pos_next, pos_cur, pos_inc;
    logic [9:0]  head_reg, head_next, head_cur;
    logic [13:0] time_reg, time_next, time_cur;
    logic [1:0]  dir_reg, dir_next, dir_cur;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        fire;
    logic        is_digit;
    logic        is_dir;
    logic [19:0] count_mac;
    logic [9:0]  head_mac;
    logic [13:0] time_mac;
    logic [9:0]  head_mod;

    assign fire    = tok_valid && (!out_valid_reg || !res_stall);
    assign tok_pop = fire;

    // plan_start wipes the parse state before this beat is looked at
    assign phase_cur    = tok.restart ? PH_HASH : phase_reg;
    assign expected_cur = tok.restart ? '0 : expected_reg;
    assign done_cur     = tok.restart ? '0 : done_reg;
    assign pos_cur      = tok.restart ? '0 : pos_reg;
    assign head_cur     = tok.restart ? '0 : head_reg;
    assign time_cur     = tok.restart ? '0 : time_reg;
    assign dir_cur      = tok.restart ? '0 : dir_reg;

    assign is_digit = (tok.cls == CC_DIGIT);
    assign is_dir   = (tok.cls == CC_PLUS) || (tok.cls == CC_MINUS) || (tok.cls == CC_TILDE);
    assign done_inc = done_cur + 16'd1;
    assign pos_inc  = pos_cur + 3'd1;

    // x10 as shift-add
    assign count_mac = ({4'b0, expected_cur} << 3) + ({4'b0, expected_cur} << 1)
                     + {16'b0, tok.digit};
    assign head_mac  = (head_cur << 3) + (head_cur << 1) + {6'b0, tok.digit};
    assign time_mac  = (time_cur << 3) + (time_cur << 1) + {10'b0, tok.digit};

    // heading is below 1000, so at most two subtractions of 360
    always_comb
    begin
        if (head_cur >= HEAD_MOD_X2)
        begin
            head_mod = head_cur - HEAD_MOD_X2;
        end
        else if (head_cur >= HEAD_MOD)
        begin
            head_mod = head_cur - HEAD_MOD;
        end
        else
        begin
            head_mod = head_cur;
        end
    end

    always_comb
    begin
        case (phase_cur)
            PH_HASH:
            begin
                phase_next = (tok.cls == CC_HASH) ? PH_COUNT : PH_DONE;
            end
            PH_COUNT:
            begin
                if (is_digit)
                begin
                    phase_next = PH_COUNT;
                end
                else
                begin
                    phase_next = (expected_cur == '0) ? PH_DONE : PH_DIR;
                end
            end
            PH_DIR:
            begin
                phase_next = is_dir ? PH_HEAD : PH_DONE;
            end
            PH_HEAD:
            begin
                if (!is_digit)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (pos_inc >= HEAD_DIGITS) ? PH_TIME : PH_HEAD;
                end
            end
            PH_TIME:
            begin
                if (!is_digit)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (pos_inc >= TIME_DIGITS) ? PH_SEMI : PH_TIME;
                end
            end
            PH_SEMI:
            begin
                if (tok.cls != CC_SEMI)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = (done_inc >= expected_cur) ? PH_DONE : PH_DIR;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_comb
    begin
        expected_next = expected_cur;
        done_next     = done_cur;
        pos_next      = pos_cur;
        head_next     = head_cur;
        time_next     = time_cur;
        dir_next      = dir_cur;
        out_next      = '0;
        case (phase_cur)
            PH_HASH:
            begin
                if (tok.cls == CC_HASH)
                begin
                    expected_next = '0;
                    done_next     = '0;
                end
                else
                begin
                    out_next.err = 1'b1;
                end
            end
            PH_COUNT:
            begin
                if (is_digit)
                begin
                    expected_next = (count_mac > {4'b0, COUNT_MAX}) ? COUNT_MAX
                                                                    : count_mac[15:0];
                end
                else if (expected_cur == '0)
                begin
                    out_next.valid = 1'b1;
                end
            end
            PH_DIR:
            begin
                if (is_dir)
                begin
                    case (tok.cls)
                        CC_PLUS:  dir_next = DIR_CW;
                        CC_MINUS: dir_next = DIR_CCW;
                        default:  dir_next = DIR_SHORTEST;
                    endcase
                    pos_next  = '0;
                    head_next = '0;
                    time_next = '0;
                end
                else
                begin
                    out_next.err = 1'b1;
                end
            end
            PH_HEAD:
            begin
                if (!is_digit)
                begin
                    out_next.err = 1'b1;
                end
                else
                begin
                    head_next = head_mac;
                    pos_next  = (pos_inc >= HEAD_DIGITS) ? '0 : pos_inc;
                end
            end
            PH_TIME:
            begin
                if (!is_digit)
                begin
                    out_next.err = 1'b1;
                end
                else
                begin
                    time_next = time_mac;
                    pos_next  = (pos_inc >= TIME_DIGITS) ? '0 : pos_inc;
                end
            end
            PH_SEMI:
            begin
                if (tok.cls == CC_SEMI)
                begin
                    out_next.ready = 1'b1;
                    out_next.dir   = dir_cur;
                    out_next.head  = head_mod[8:0];
                    out_next.tms   = time_cur;
                    out_next.idx   = done_cur;
                    done_next      = done_inc;
                    out_next.valid = (done_inc >= expected_cur);
                end
                else
                begin
                    out_next.err = 1'b1;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && res_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HASH;
            expected_reg  <= '0;
            done_reg      <= '0;
            pos_reg       <= '0;
            head_reg      <= '0;
            time_reg      <= '0;
            dir_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                phase_reg    <= phase_next;
                expected_reg <= expected_next;
                done_reg     <= done_next;
                pos_reg      <= pos_next;
                head_reg     <= head_next;
                time_reg     <= time_next;
                dir_reg      <= dir_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

>>> hdl/roll_plan_text_parser_core.sv
// roll plan text parser: one text byte per beat, one result beat per input beat
// path from input accept to result valid: queue slot, then result register
// throughput: 1 beat per cycle while out_stall is low, set by the parser step in rppt_back
// reset: parser waits for '#', queue empty, no result pending
// depends on rppt_pkg, rppt_front, rppt_queue, rppt_back

module roll_plan_text_parser_core
    import rppt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  text_byte,
    input  logic        plan_start,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        command_ready,
    output logic [1:0]  turn_direction,
    output logic [8:0]  heading_deg,
    output logic [13:0] roll_time_ms,
    output logic [15:0] command_index,
    output logic        plan_valid,
    output logic        plan_error
);

    token_t  front_tok;
    token_t  queue_tok;
    logic    queue_full;
    logic    queue_not_empty;
    logic    queue_pop;
    result_t res;

    rppt_front u_front (
        .text_byte  (text_byte),
        .plan_start (plan_start),
        .token      (front_tok)
    );

    rppt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !queue_full),
        .push_data (front_tok),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head_data (queue_tok)
    );

    rppt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (queue_not_empty),
        .tok       (queue_tok),
        .tok_pop   (queue_pop),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    assign in_stall       = queue_full;
    assign command_ready  = res.ready;
    assign turn_direction = res.dir;
    assign heading_deg    = res.head;
    assign roll_time_ms   = res.tms;
    assign command_index  = res.idx;
    assign plan_valid     = res.valid;
    assign plan_error     = res.err;

endmodule

>>> verif/roll_plan_text_parser_core_test.sv
// testbench for roll_plan_text_parser_core: opening table, then random plans, every beat scored
// depends on rppt_pkg and the parser rtl

`timescale 1ns / 1ps

module roll_plan_text_parser_core_test
    import rppt_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PLAN_BYTES  = 400;

    localparam result_t NO_REPORT   = '{1'b0, 2'd0, 9'd0, 14'd0, 16'd0, 1'b0, 1'b0};
    localparam result_t FOUND_ERROR = '{1'b0, 2'd0, 9'd0, 14'd0, 16'd0, 1'b0, 1'b1};
    localparam result_t PLAN_OK     = '{1'b0, 2'd0, 9'd0, 14'd0, 16'd0, 1'b1, 1'b0};
    localparam result_t LAST_CMD    = '{1'b1, DIR_CCW, 9'd279, 14'd9999, 16'd0, 1'b1, 1'b0};

    typedef struct packed {
        logic [7:0] text;
        logic       start;
        logic       fixed;
        result_t    want;
    } stim_row_t;

    // fixed rows carry their report literally, the rest go through the parser model
    localparam stim_row_t OPENING_ROWS [24] = '{
        '{8'h00,    1'b0, 1'b1, FOUND_ERROR},  // first byte after reset, no restart, no hash
        '{8'hFF,    1'b0, 1'b1, NO_REPORT},    // ignored once the plan is over
        '{CH_HASH,  1'b1, 1'b1, NO_REPORT},
        '{8'h41,    1'b0, 1'b1, PLAN_OK},      // empty count
        '{CH_HASH,  1'b1, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},    // five nines saturate the count
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{8'h2C,    1'b0, 1'b0, NO_REPORT},
        '{8'h80,    1'b0, 1'b1, FOUND_ERROR},  // bad direction char
        '{CH_HASH,  1'b1, 1'b0, NO_REPORT},
        '{8'h31,    1'b0, 1'b0, NO_REPORT},
        '{8'h0A,    1'b0, 1'b0, NO_REPORT},
        '{CH_MINUS, 1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_NINE,  1'b0, 1'b0, NO_REPORT},
        '{CH_SEMI,  1'b0, 1'b1, LAST_CMD}
    };

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  text_byte  = 8'h00;
    logic        plan_start = 1'b0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic        command_ready;
    logic [1:0]  turn_direction;
    logic [8:0]  heading_deg;
    logic [13:0] roll_time_ms;
    logic [15:0] command_index;
    logic        plan_valid;
    logic        plan_error;

    // parser model state
    phase_t      phase;
    logic [15:0] want_count;
    logic [15:0] done_count;
    logic [2:0]  digit_pos;
    logic [9:0]  head_acc;
    logic [13:0] time_acc;
    logic [1:0]  dir_pend;

    stim_row_t   plan_text [$];
    result_t     parser_reports [$];
    int          taken_bytes = 0;
    int          bad_fields  = 0;
    int          cycle_count = 0;

    roll_plan_text_parser_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .plan_start     (plan_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .command_ready  (command_ready),
        .turn_direction (turn_direction),
        .heading_deg    (heading_deg),
        .roll_time_ms   (roll_time_ms),
        .command_index  (command_index),
        .plan_valid     (plan_valid),
        .plan_error     (plan_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        phase      = PH_HASH;
        want_count = '0;
        done_count = '0;
        digit_pos  = '0;
        head_acc   = '0;
        time_acc   = '0;
        dir_pend   = '0;
    endfunction

    function automatic result_t parse_plan_byte(logic [7:0] b, logic restart);
        result_t     r;
        logic        is_digit;
        logic [3:0]  d;
        int unsigned cnt;
        r = NO_REPORT;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        d = 4'(b - CH_ZERO);
        if (restart)
            clear_parser();
        case (phase)
            PH_HASH:
                if (b == CH_HASH)
                begin
                    want_count = '0;
                    done_count = '0;
                    phase = PH_COUNT;
                end
                else
                begin
                    r.err = 1'b1;
                    phase = PH_DONE;
                end
            PH_COUNT:
                if (is_digit)
                begin
                    cnt = want_count * 10 + d;
                    want_count = (cnt > COUNT_MAX) ? COUNT_MAX : 16'(cnt);
                end
                else if (want_count == 0)
                begin
                    r.valid = 1'b1;
                    phase = PH_DONE;
                end
                else
                    phase = PH_DIR;
            PH_DIR:
                if (b == CH_PLUS || b == CH_MINUS || b == CH_TILDE)
                begin
                    dir_pend = (b == CH_PLUS) ? DIR_CW : ((b == CH_MINUS) ? DIR_CCW : DIR_SHORTEST);
                    digit_pos = '0;
                    head_acc = '0;
                    time_acc = '0;
                    phase = PH_HEAD;
                end
                else
                begin
                    r.err = 1'b1;
                    phase = PH_DONE;
                end
            PH_HEAD, PH_TIME:
                if (!is_digit)
                begin
                    r.err = 1'b1;
                    phase = PH_DONE;
                end
                else if (phase == PH_HEAD)
                begin
                    head_acc = 10'(head_acc * 10 + d);
                    digit_pos = digit_pos + 3'd1;
                    if (digit_pos >= HEAD_DIGITS)
                    begin
                        digit_pos = '0;
                        phase = PH_TIME;
                    end
                end
                else
                begin
                    time_acc = 14'(time_acc * 10 + d);
                    digit_pos = digit_pos + 3'd1;
                    if (digit_pos >= TIME_DIGITS)
                    begin
                        digit_pos = '0;
                        phase = PH_SEMI;
                    end
                end
            PH_SEMI:
                if (b == CH_SEMI)
                begin
                    r.ready = 1'b1;
                    r.dir   = dir_pend;
                    r.head  = 9'(head_acc % HEAD_MOD);
                    r.tms   = time_acc;
                    r.idx   = done_count;
                    done_count = done_count + 16'd1;
                    if (done_count >= want_count)
                    begin
                        r.valid = 1'b1;
                        phase = PH_DONE;
                    end
                    else
                        phase = PH_DIR;
                end
                else
                begin
                    r.err = 1'b1;
                    phase = PH_DONE;
                end
            default:
                phase = PH_DONE;
        endcase
        return r;
    endfunction

    function automatic void add_row(logic [7:0] b, logic s);
        plan_text.push_back('{b, s, 1'b0, NO_REPORT});
    endfunction

    // now and then a byte of a well-formed plan is replaced by noise
    function automatic logic [7:0] garble(logic [7:0] b);
        if ($urandom_range(0, 39) == 0)
            return 8'($urandom_range(0, 255));
        return b;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic void add_random_plans();
        int         parsed;
        int         ncmd;
        int         n;
        int         first;
        logic [7:0] sep;
        logic [1:0] pick;
        parsed = 0;
        while (parsed < PLAN_BYTES)
        begin
            first = plan_text.size();
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_row(8'($urandom_range(0, 255)), (i == 0) ? 1'($urandom) : 1'b0);
            end
            else
            begin
                add_row(garble(CH_HASH), ($urandom_range(0, 7) != 0));
                if ($urandom_range(0, 11) == 0)
                begin
                    // long count, usually saturating; the plan gets cut short
                    for (int i = 0; i < 6; i++)
                        add_row(rand_digit(), 1'b0);
                    ncmd = 2;
                end
                else
                begin
                    ncmd = $urandom_range(0, 4);
                    if ($urandom_range(0, 3) == 0)
                        add_row(CH_ZERO, 1'b0);
                    if (ncmd != 0 || $urandom_range(0, 1) == 0)
                        add_row(CH_ZERO + 8'(ncmd), 1'b0);
                end
                do
                    sep = 8'($urandom_range(0, 255));
                while (sep >= CH_ZERO && sep <= CH_NINE);
                add_row(sep, 1'b0);
                for (int c = 0; c < ncmd; c++)
                begin
                    pick = 2'($urandom_range(0, 2));
                    add_row(garble((pick == 0) ? CH_PLUS : ((pick == 1) ? CH_MINUS : CH_TILDE)),
                            1'b0);
                    for (int i = 0; i < 7; i++)
                        add_row(garble(rand_digit()), 1'b0);
                    add_row(garble(CH_SEMI), 1'b0);
                end
            end
            parsed += plan_text.size() - first;
            // trailing bytes mostly land after the plan is over
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_row(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            bad_fields++;
        end
    endfunction

    // score accepted input beats and result beats
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && in_valid && !in_stall)
        begin
            r = parse_plan_byte(text_byte, plan_start);
            parser_reports.push_back(plan_text[taken_bytes].fixed ? plan_text[taken_bytes].want : r);
            taken_bytes++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (parser_reports.size() == 0)
            begin
                $display("%0t: result beat with no byte waiting for it", $time);
                bad_fields++;
            end
            else
            begin
                r = parser_reports.pop_front();
                check_field("command_ready", r.ready, command_ready);
                check_field("turn_direction", r.dir, turn_direction);
                check_field("heading_deg", r.head, heading_deg);
                check_field("roll_time_ms", r.tms, roll_time_ms);
                check_field("command_index", r.idx, command_index);
                check_field("plan_valid", r.valid, plan_valid);
                check_field("plan_error", r.err, plan_error);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d reports outstanding", $time, parser_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int  hold;
        int  beats;
        bit  calm;
        beats = 0;
        calm = 1'b0;
        forever
        begin
            if (beats % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(rst_n && out_valid))
                @(posedge clk);
            beats++;
        end
    end

    initial
    begin
        int  gap;
        bit  calm;
        calm = 1'b0;
        clear_parser();
        foreach (OPENING_ROWS[i])
            plan_text.push_back(OPENING_ROWS[i]);
        add_random_plans();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < plan_text.size(); i++)
        begin
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid   <= 1'b1;
            text_byte  <= plan_text[i].text;
            plan_start <= plan_text[i].start;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        while (taken_bytes < plan_text.size() || parser_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (bad_fields == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
